// ===== rtl/core/pfra_pkg.sv =====
package pfra_pkg;

  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned MAX_FRAMES_DEF = 1024;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // frame map word: frames held in one memory row
  localparam int unsigned WORD_W = 16;
  localparam int unsigned WORD_SH = 4;

  // page divider
  localparam int unsigned DIV_W = 48;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE         = 2'd0,
    STS_NO_SPACE     = 2'd1,
    STS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_SIZE,
    ST_CHECK,
    ST_BOUNDS,
    ST_DIV_OFF,
    ST_SCAN,
    ST_RMW_RD,
    ST_RMW_WR
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/pfra_div.sv =====
module pfra_div #(
  parameter int unsigned PAGE_BYTES = pfra_pkg::PAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pfra_pkg::div_req_t req,
  output pfra_pkg::div_rsp_t rsp
);

  localparam int unsigned DW = pfra_pkg::DIV_W;
  localparam int unsigned PW = $clog2(PAGE_BYTES);

  logic [DW-1:0] quot_r;
  logic          rem_nz_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= req.start;
    end
  end

  // page size is a power of two: quotient by shift, remainder by mask
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r   <= req.dividend >> PW;
      rem_nz_r <= |req.dividend[PW-1:0];
    end
  end

  assign rsp.done   = done_r;
  assign rsp.rem_nz = rem_nz_r;
  assign rsp.quot   = quot_r;

endmodule

// ===== rtl/core/pfra_ram.sv =====
module pfra_ram #(
  parameter int unsigned DEPTH = pfra_pkg::MAX_FRAMES_DEF / pfra_pkg::WORD_W,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = pfra_pkg::WORD_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/page_frame_run_allocator_top.sv =====
// first-fit page frame allocator over one region: one used bit per frame, kept in a
// single-port-read map memory of 16-frame words. after reset a clearing pass writes the
// whole map with busy high. a request is taken when start is high and busy is low;
// exactly one result word follows, shown on the out_ ports for one cycle with out_strobe
// high, and it must be taken there, as the receiver cannot hold it off. PAGE_BYTES must
// be a power of two: the size is rounded to pages by a shift. allocate then checks the
// size, scans one map word per cycle and marks the run with a read and a write of each
// word touched. free checks the bounds, finds its first frame with a second shift and
// clears the run with a read and a write of each word touched. a rejected request ends
// after the size rounding and its checks. busy falls in the cycle the result is shown.
module page_frame_run_allocator_top #(
  parameter int unsigned MAX_FRAMES = pfra_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BYTES = pfra_pkg::PAGE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_command,
  input  logic [pfra_pkg::SIZE_W-1:0]     in_size_bytes,
  input  logic [pfra_pkg::ADDR_W-1:0]     in_address,
  output logic                            out_strobe,
  output logic [pfra_pkg::ADDR_W-1:0]     out_result_address,
  output logic [pfra_pkg::STATUS_W-1:0]   out_status,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pfra_pkg::ADDR_W-1:0]     cfg_data
);

  localparam int unsigned AW     = pfra_pkg::ADDR_W;
  localparam int unsigned CW     = pfra_pkg::CNT_W;
  localparam int unsigned WW     = pfra_pkg::WORD_W;
  localparam int unsigned SH     = pfra_pkg::WORD_SH;
  localparam int unsigned DVW    = pfra_pkg::DIV_W;
  localparam int unsigned FW     = $clog2(MAX_FRAMES + 1);
  localparam int unsigned RW     = FW + 1;
  localparam int unsigned NWORDS = (MAX_FRAMES + WW - 1) / WW;
  localparam int unsigned WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned WCW    = $clog2(NWORDS + 1);
  localparam int unsigned XW     = WCW + SH;
  localparam int unsigned PW     = $clog2(PAGE_BYTES);
  localparam int unsigned PGW    = 33 - PW;
  localparam int unsigned OFFW   = FW + PW + 1;
  localparam int unsigned PGOFFW = PGW + PW + 1;

  pfra_pkg::state_t  state_r, state_nxt;
  pfra_pkg::status_t fin_status;
  pfra_pkg::status_t out_status_r;
  pfra_pkg::div_req_t div_req;
  pfra_pkg::div_rsp_t div_rsp;

  logic [AW-1:0]  base_r;
  logic [CW-1:0]  fcount_r;
  logic           cmd_r;
  logic [AW-1:0]  addr_r;
  logic [PGW-1:0] pages_r;
  logic [FW-1:0]  lo_r;
  logic [FW-1:0]  hi_r;
  logic [WCW-1:0] word_r;
  logic [WCW-1:0] dword_r;
  logic           dval_r;
  logic [RW-1:0]  run_r;
  logic [AW:0]    range_end_r;
  logic [AW:0]    region_end_r;
  logic           out_strobe_r;
  logic [AW-1:0]  out_addr_r;

  logic [FW-1:0]   nframes;
  logic [WCW-1:0]  nwa;
  logic [FW-1:0]   pages_f;
  logic [WCW-1:0]  last_w;
  logic [OFFW-1:0] lo_bytes;
  logic [OFFW-1:0] region_bytes;
  logic [PGOFFW-1:0] run_bytes;
  logic            alloc_bad;
  logic            range_bad;
  logic            fin;
  logic            scan_issue;

  logic           mem_we;
  logic [WAW-1:0] mem_waddr;
  logic [WW-1:0]  mem_wdata;
  logic [WAW-1:0] mem_raddr;
  logic [WW-1:0]  mem_rdata;
  logic [WW-1:0]  rmw_data;

  logic [WW-1:0] scan_used;
  logic [WW-1:0] scan_found;
  logic [SH-1:0] scan_pos [WW];
  logic [RW-1:0] scan_run [WW];
  logic [WW-1:0] scan_hit;
  logic          hit_any;
  logic [SH-1:0] hit_j;
  logic [RW-1:0] run_after;
  logic [XW-1:0] end_idx;
  logic [FW-1:0] hit_lo;
  logic [FW-1:0] hit_hi;
  logic [FW-1:0] free_lo;

  pfra_div #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  pfra_ram #(
    .DEPTH(NWORDS),
    .AW   (WAW),
    .DW   (WW)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // frame count above the map size is clamped
  always_comb begin
    if (32'(fcount_r) > 32'(MAX_FRAMES)) begin
      nframes = FW'(MAX_FRAMES);
    end else begin
      nframes = FW'(fcount_r);
    end
    nwa          = WCW'((XW'(nframes) + XW'(WW - 1)) >> SH);
    pages_f      = FW'(pages_r);
    last_w       = WCW'((hi_r - FW'(1)) >> SH);
    lo_bytes     = OFFW'(lo_r) * OFFW'(PAGE_BYTES);
    region_bytes = OFFW'(nframes) * OFFW'(PAGE_BYTES);
    run_bytes    = PGOFFW'(pages_r) * PGOFFW'(PAGE_BYTES);
    alloc_bad    = (pages_r == '0) || (32'(pages_r) > 32'(nframes));
    range_bad    = (addr_r < base_r) || (range_end_r > region_end_r);
    free_lo      = FW'(div_rsp.quot);
  end

  // word scan: frames past the region count as used
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      scan_used[j] = mem_rdata[j] |
                     (((XW'(dword_r) << SH) + XW'(j)) >= XW'(nframes));
    end
  end

  // run length ending at each bit, from the nearest used bit below it
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      scan_found[j] = 1'b0;
      scan_pos[j]   = '0;
      for (int k = 0; k <= j; k++) begin
        if (scan_used[k]) begin
          scan_found[j] = 1'b1;
          scan_pos[j]   = SH'(k);
        end
      end
      if (scan_used[j]) begin
        scan_run[j] = '0;
      end else if (scan_found[j]) begin
        scan_run[j] = RW'(j) - RW'(scan_pos[j]);
      end else begin
        scan_run[j] = run_r + RW'(j) + RW'(1);
      end
      scan_hit[j] = !scan_used[j] && (scan_run[j] == RW'(pages_f));
    end
    hit_any = |scan_hit;
    hit_j   = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (scan_hit[j]) begin
        hit_j = SH'(j);
      end
    end
    if (scan_found[WW-1]) begin
      run_after = RW'(WW - 1) - RW'(scan_pos[WW-1]);
    end else begin
      run_after = run_r + RW'(WW);
    end
    end_idx = (XW'(dword_r) << SH) + XW'(hit_j);
    hit_hi  = FW'(end_idx + XW'(1));
    hit_lo  = FW'(end_idx + XW'(1) - XW'(pages_f));
  end

  // read-modify-write of one map word: set on allocate, clear on free
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      if ((((XW'(word_r) << SH) + XW'(j)) >= XW'(lo_r)) &&
          (((XW'(word_r) << SH) + XW'(j)) < XW'(hi_r))) begin
        rmw_data[j] = (cmd_r == pfra_pkg::CMD_ALLOC);
      end else begin
        rmw_data[j] = mem_rdata[j];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfra_pkg::ST_CLEAR: begin
        if (word_r == WCW'(NWORDS - 1)) begin
          state_nxt = pfra_pkg::ST_IDLE;
        end
      end
      pfra_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = pfra_pkg::ST_DIV_SIZE;
        end
      end
      pfra_pkg::ST_DIV_SIZE: begin
        if (div_rsp.done) begin
          state_nxt = pfra_pkg::ST_CHECK;
        end
      end
      pfra_pkg::ST_CHECK: begin
        if (cmd_r == pfra_pkg::CMD_FREE) begin
          state_nxt = pfra_pkg::ST_BOUNDS;
        end else if (alloc_bad) begin
          state_nxt = pfra_pkg::ST_IDLE;
        end else begin
          state_nxt = pfra_pkg::ST_SCAN;
        end
      end
      pfra_pkg::ST_BOUNDS: begin
        state_nxt = range_bad ? pfra_pkg::ST_IDLE : pfra_pkg::ST_DIV_OFF;
      end
      pfra_pkg::ST_DIV_OFF: begin
        if (div_rsp.done) begin
          state_nxt = (pages_r == '0) ? pfra_pkg::ST_IDLE : pfra_pkg::ST_RMW_RD;
        end
      end
      pfra_pkg::ST_SCAN: begin
        if (dval_r && hit_any) begin
          state_nxt = pfra_pkg::ST_RMW_RD;
        end else if (dval_r && (dword_r == nwa - WCW'(1))) begin
          state_nxt = pfra_pkg::ST_IDLE;
        end
      end
      pfra_pkg::ST_RMW_RD: begin
        state_nxt = pfra_pkg::ST_RMW_WR;
      end
      pfra_pkg::ST_RMW_WR: begin
        state_nxt = (word_r == last_w) ? pfra_pkg::ST_IDLE : pfra_pkg::ST_RMW_RD;
      end
      default: begin
        state_nxt = pfra_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy             = state_r != pfra_pkg::ST_IDLE;
    mem_we           = 1'b0;
    mem_waddr        = word_r[WAW-1:0];
    mem_wdata        = '0;
    mem_raddr        = word_r[WAW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = DVW'(in_size_bytes);
    fin              = 1'b0;
    fin_status       = pfra_pkg::STS_DONE;
    scan_issue       = 1'b0;
    case (state_r)
      pfra_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      pfra_pkg::ST_IDLE: begin
        div_req.start = start;
      end
      pfra_pkg::ST_CHECK: begin
        if ((cmd_r == pfra_pkg::CMD_ALLOC) && alloc_bad) begin
          fin        = 1'b1;
          fin_status = pfra_pkg::STS_NO_SPACE;
        end
      end
      pfra_pkg::ST_BOUNDS: begin
        if (range_bad) begin
          fin        = 1'b1;
          fin_status = pfra_pkg::STS_OUT_OF_RANGE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = addr_r - base_r;
        end
      end
      pfra_pkg::ST_DIV_OFF: begin
        if (div_rsp.done && (pages_r == '0)) begin
          fin = 1'b1;
        end
      end
      pfra_pkg::ST_SCAN: begin
        scan_issue = word_r < nwa;
        if (dval_r && !hit_any && (dword_r == nwa - WCW'(1))) begin
          fin        = 1'b1;
          fin_status = pfra_pkg::STS_NO_SPACE;
        end
      end
      pfra_pkg::ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rmw_data;
        fin       = word_r == last_w;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfra_pkg::ST_CLEAR;
      word_r       <= '0;
      dval_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      base_r       <= '0;
      fcount_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= fin;
      if (cfg_we) begin
        case (cfg_index)
          pfra_pkg::REG_REGION_BASE: base_r   <= cfg_data;
          pfra_pkg::REG_FRAME_COUNT: fcount_r <= cfg_data[CW-1:0];
          default: base_r <= base_r;
        endcase
      end
      case (state_r)
        pfra_pkg::ST_CLEAR: begin
          if (word_r == WCW'(NWORDS - 1)) begin
            word_r <= '0;
          end else begin
            word_r <= word_r + WCW'(1);
          end
        end
        pfra_pkg::ST_CHECK: begin
          word_r <= '0;
          dval_r <= 1'b0;
        end
        pfra_pkg::ST_DIV_OFF: begin
          if (div_rsp.done) begin
            word_r <= WCW'(free_lo >> SH);
          end
        end
        pfra_pkg::ST_SCAN: begin
          // next word is fetched while this one is checked
          dval_r <= scan_issue;
          if (dval_r && hit_any) begin
            word_r <= WCW'(hit_lo >> SH);
          end else if (scan_issue) begin
            word_r <= word_r + WCW'(1);
          end
        end
        pfra_pkg::ST_RMW_WR: begin
          if (word_r != last_w) begin
            word_r <= word_r + WCW'(1);
          end
        end
        default: begin
          dval_r <= dval_r;
        end
      endcase
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (state_r == pfra_pkg::ST_IDLE && start) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
    end
    if (state_r == pfra_pkg::ST_DIV_SIZE && div_rsp.done) begin
      pages_r <= PGW'(div_rsp.quot) + PGW'(div_rsp.rem_nz);
    end
    if (state_r == pfra_pkg::ST_CHECK) begin
      run_r        <= '0;
      range_end_r  <= (AW+1)'(addr_r) + (AW+1)'(run_bytes);
      region_end_r <= (AW+1)'(base_r) + (AW+1)'(region_bytes);
    end
    if (state_r == pfra_pkg::ST_DIV_OFF && div_rsp.done) begin
      lo_r <= free_lo;
      hi_r <= free_lo + pages_f;
    end
    if (state_r == pfra_pkg::ST_SCAN) begin
      dword_r <= word_r;
      if (dval_r) begin
        run_r <= run_after;
      end
      if (dval_r && hit_any) begin
        lo_r <= hit_lo;
        hi_r <= hit_hi;
      end
    end
    if (fin) begin
      out_status_r <= fin_status;
      if ((cmd_r == pfra_pkg::CMD_ALLOC) && (fin_status == pfra_pkg::STS_DONE)) begin
        out_addr_r <= base_r + AW'(lo_bytes);
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

  a_strobe_when_idle: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_strobe |-> (state_r == pfra_pkg::ST_IDLE)
  ) else $error("result word shown while a request is still in progress");

  a_no_result_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe
  ) else $error("result word right after a request was taken");

  a_scan_no_write: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == pfra_pkg::ST_SCAN) |-> !mem_we
  ) else $error("frame map written during scan");

  a_div_done_expected: assert property (
    @(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == pfra_pkg::ST_DIV_SIZE) ||
                      (state_r == pfra_pkg::ST_DIV_OFF))
  ) else $error("divider finished outside a divide step");

endmodule

// ===== sim/page_frame_run_allocator_top_tb.sv =====
`timescale 1ns / 100ps

module page_frame_run_allocator_top_tb;
  import pfra_pkg::*;

  localparam longint unsigned PAGE = PAGE_BYTES_DEF;
  localparam longint unsigned FRAMES = MAX_FRAMES_DEF;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_command = CMD_ALLOC;
  logic [SIZE_W-1:0]   in_size_bytes = '0;
  logic [ADDR_W-1:0]   in_address = '0;
  logic                out_strobe;
  logic [ADDR_W-1:0]   out_result_address;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_REGION_BASE;
  logic [ADDR_W-1:0]   cfg_data = '0;

  page_frame_run_allocator_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_size_bytes      (in_size_bytes),
    .in_address         (in_address),
    .out_strobe         (out_strobe),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the frame map and the two registers
  bit                frame_used [0:MAX_FRAMES_DEF-1];
  logic [ADDR_W-1:0] base_cfg = '0;
  logic [CNT_W-1:0]  count_cfg = '0;

  request_t request_q [$];
  answer_t  answer_q [$];
  bit       steady = 1'b0;
  int       err_count = 0;
  int       n_alloc = 0;
  int       n_free = 0;
  int       n_no_space = 0;
  int       n_out_of_range = 0;
  int       n_settings = 0;
  int       quiet = 0;

  task automatic first_fit_update(input logic cmd, input logic [SIZE_W-1:0] size,
                                  input logic [ADDR_W-1:0] addr, output answer_t ans);
    longint unsigned usable, pages, run, first, region_end, range_end, sz, a, b, i;
    bit found;
    usable = (64'(count_cfg) > FRAMES) ? FRAMES : 64'(count_cfg);
    sz = 64'(size);
    a = 64'(addr);
    b = 64'(base_cfg);
    pages = (sz + PAGE - 1) / PAGE;
    ans.addr = '0;
    ans.status = STS_DONE;
    if (cmd == CMD_ALLOC) begin
      ans.status = STS_NO_SPACE;
      if (pages != 0 && pages <= usable) begin
        run = 0;
        found = 1'b0;
        for (i = 0; i < usable && !found; i++) begin
          if (frame_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == pages) begin
              found = 1'b1;
              first = i + 1 - run;
              for (longint unsigned k = first; k <= i; k++) frame_used[k] = 1'b1;
              ans.addr = ADDR_W'(b + first * PAGE);
              ans.status = STS_DONE;
            end
          end
        end
      end
    end else begin
      // bounds at full width, no wrap
      region_end = b + usable * PAGE;
      range_end = a + pages * PAGE;
      if (a < b || range_end > region_end) begin
        ans.status = STS_OUT_OF_RANGE;
      end else begin
        first = (a - b) / PAGE;
        for (i = 0; i < pages; i++) begin
          if (first + i < usable) frame_used[first + i] = 1'b0;
        end
      end
    end
  endtask

  // driver: head of the queue stays until the block takes it
  always @(posedge clk) begin
    answer_t ans;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        first_fit_update(in_command, in_size_bytes, in_address, ans);
        answer_q.push_back(ans);
        if (in_command == CMD_ALLOC) n_alloc++;
        else n_free++;
        if (ans.status == STS_NO_SPACE) n_no_space++;
        if (ans.status == STS_OUT_OF_RANGE) n_out_of_range++;
        void'(request_q.pop_front());
      end
      if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
        start <= 1'b1;
        in_command <= request_q[0].cmd;
        in_size_bytes <= request_q[0].size;
        in_address <= request_q[0].addr;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_strobe) begin
      if (answer_q.size() == 0) begin
        $error("result word with nothing outstanding: address %0h status %0d",
               out_result_address, out_status);
        err_count++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (out_result_address !== exp_ans.addr) begin
          $error("result_address: expected %0h, got %0h", exp_ans.addr, out_result_address);
          err_count++;
        end
        if (out_status !== exp_ans.status) begin
          $error("status: expected %0d, got %0d", exp_ans.status, out_status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("page_frame_run_allocator_top verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic queue_request(input logic cmd, input longint unsigned size,
                               input longint unsigned addr);
    request_t r;
    r.cmd = cmd;
    r.size = size[SIZE_W-1:0];
    r.addr = addr[ADDR_W-1:0];
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (request_q.size() != 0 || start || busy || answer_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REGION_BASE) base_cfg = data;
    else count_cfg = data[CNT_W-1:0];
    n_settings++;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  task automatic queue_random_request();
    int kind, np, idx, maxp, usable;
    longint unsigned size, addr;
    usable = int'((64'(count_cfg) > FRAMES) ? FRAMES : 64'(count_cfg));
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      np = $urandom_range(0, 99);
      if (np < 80) np = $urandom_range(1, 8);
      else if (np < 95) np = $urandom_range(9, 64);
      else np = 0;
      if (np == 0) size = 64'($urandom);
      else size = (np - 1) * PAGE + 64'($urandom_range(1, PAGE_BYTES_DEF));
      queue_request(CMD_ALLOC, size, 64'(rand_addr()));
    end else if (kind < 90 && usable > 0) begin
      idx = $urandom_range(0, usable - 1);
      maxp = usable - idx;
      if ($urandom_range(0, 9) == 0) np = maxp;
      else np = $urandom_range(0, (maxp < 12) ? maxp : 12);
      size = (np == 0) ? 0 : np * PAGE - 64'($urandom_range(0, PAGE_BYTES_DEF - 1));
      addr = base_cfg + idx * PAGE;
      if ($urandom_range(0, 3) == 0) addr = addr + 64'($urandom_range(1, PAGE_BYTES_DEF - 1));
      queue_request(CMD_FREE, size, addr);
    end else begin
      queue_request(1'($urandom_range(0, 1)), 64'($urandom), 64'(rand_addr()));
    end
  endtask

  initial begin
    longint unsigned b;
    logic [ADDR_W-1:0] r;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty region straight after reset
    queue_request(CMD_ALLOC, PAGE, 0);
    queue_request(CMD_FREE, 0, 0);
    wait_idle();

    b = 64'h0000_1000_0000;
    write_reg(REG_REGION_BASE, ADDR_W'(b));
    write_reg(REG_FRAME_COUNT, ADDR_W'(FRAMES));
    queue_request(CMD_ALLOC, 0, 0);
    queue_request(CMD_ALLOC, 1, 0);
    queue_request(CMD_ALLOC, PAGE, 48'hFFFF_FFFF_FFFF);
    queue_request(CMD_ALLOC, PAGE + 1, 0);
    queue_request(CMD_ALLOC, 32'hFFFF_FFFF, 0);
    // unaligned free lands in frame 1
    queue_request(CMD_FREE, 1, b + PAGE + 123);
    queue_request(CMD_ALLOC, PAGE, 0);
    queue_request(CMD_FREE, 1, b - 1);
    queue_request(CMD_FREE, 2 * PAGE, b + 1023 * PAGE);
    queue_request(CMD_FREE, PAGE, b + 1023 * PAGE);
    queue_request(CMD_FREE, 0, b);
    queue_request(CMD_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_request(CMD_ALLOC, 1020 * PAGE, 0);
    queue_request(CMD_ALLOC, 1, 0);
    queue_request(CMD_FREE, FRAMES * PAGE, b);
    queue_request(CMD_ALLOC, FRAMES * PAGE, 0);
    wait_idle();

    // region at the top of the address space, count above the frame limit
    b = 64'h0000_FFFF_FFFF_F000;
    write_reg(REG_REGION_BASE, ADDR_W'(b));
    write_reg(REG_FRAME_COUNT, {37'h1F_FFFF_FFFF, 11'h7FF});
    queue_request(CMD_FREE, FRAMES * PAGE, b);
    queue_request(CMD_ALLOC, 2 * PAGE, 0);
    queue_request(CMD_ALLOC, PAGE, 0);
    queue_request(CMD_FREE, PAGE, 48'h1000);
    queue_request(CMD_FREE, PAGE, b);
    wait_idle();

    // unaligned base, single frame
    b = 64'h123;
    write_reg(REG_REGION_BASE, ADDR_W'(b));
    write_reg(REG_FRAME_COUNT, ADDR_W'(1));
    queue_request(CMD_ALLOC, 1, 0);
    queue_request(CMD_ALLOC, 1, 0);
    queue_request(CMD_FREE, 1, b + PAGE - 1);
    queue_request(CMD_FREE, PAGE, b);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      repeat (4) @(posedge clk);
      r = rand_addr();
      n = 135;
      case (ph)
        0: begin
          write_reg(REG_REGION_BASE, {r[ADDR_W-1:12], 12'h0});
          write_reg(REG_FRAME_COUNT, ADDR_W'(FRAMES));
        end
        1: begin
          write_reg(REG_REGION_BASE, {r[ADDR_W-1:12], 12'h0});
          write_reg(REG_FRAME_COUNT, ADDR_W'($urandom_range(1, 40)));
        end
        2: begin
          write_reg(REG_REGION_BASE, {r[ADDR_W-1:12], 12'h0});
          write_reg(REG_FRAME_COUNT, rand_addr() | 48'h7FF);
        end
        3: begin
          write_reg(REG_REGION_BASE, r);
          write_reg(REG_FRAME_COUNT, ADDR_W'($urandom_range(0, 2047)));
        end
        4: begin
          write_reg(REG_REGION_BASE, '0);
          write_reg(REG_FRAME_COUNT, '0);
          n = 60;
        end
        default: begin
          write_reg(REG_REGION_BASE, 48'hFFFF_FFFF_F000);
          write_reg(REG_FRAME_COUNT, ADDR_W'($urandom_range(1000, 1024)));
        end
      endcase
      steady = (ph == 0);
      repeat (n) queue_random_request();
    end

    wait_idle();
    repeat (300) @(posedge clk);
    $display("ran %0d allocate and %0d free requests over %0d register writes",
             n_alloc, n_free, n_settings);
    $display("%0d answers were no-space, %0d were out-of-range", n_no_space, n_out_of_range);
    if (err_count == 0 && answer_q.size() == 0) begin
      $display("page_frame_run_allocator_top verification clean");
    end else begin
      $display("page_frame_run_allocator_top verification failed");
    end
    $finish;
  end

endmodule
